// ----- rtl/gclt_pkg.sv -----
// Shared constants, widths and the descriptor word for the grid cell traversal block.
package gclt_pkg;

  localparam int MAP_CELLS_DEF  = 32;
  localparam int TIME_FRAC_DEF  = 24;
  localparam int GUARD_CELLS    = 64;
  localparam int COUNT_W        = $clog2(GUARD_CELLS + 1);
  localparam int CELL_W         = 5;
  localparam int COORD_W        = 16;
  localparam int CFG_W          = 16;
  localparam int IN_FRAC        = 4;
  localparam int EDGE_W         = CFG_W + IN_FRAC;
  localparam int NUM_W          = EDGE_W + 1;
  localparam int TIME_FRAC_MAX  = 32;
  localparam int TIME_W_MAX     = NUM_W + TIME_FRAC_MAX + COUNT_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam logic [CFG_W-1:0] CELL_SIZE_RST = 16'd256;

  typedef struct packed {
    logic                  oor;
    logic [CELL_W-1:0]     scx;
    logic [CELL_W-1:0]     scy;
    logic [CELL_W-1:0]     gcx;
    logic [CELL_W-1:0]     gcy;
    logic                  dxn;
    logic                  dxz;
    logic                  dyn;
    logic                  dyz;
    logic [TIME_W_MAX-1:0] tx;
    logic [TIME_W_MAX-1:0] ty;
    logic [TIME_W_MAX-1:0] dtx;
    logic [TIME_W_MAX-1:0] dty;
  } desc_t;

endpackage

// ----- rtl/gclt_if.sv -----
// Segment input and cell result channel interfaces.
interface gclt_in_if;
  logic                         valid;
  logic                         ready;
  logic [gclt_pkg::COORD_W-1:0] start_x;
  logic [gclt_pkg::COORD_W-1:0] start_y;
  logic [gclt_pkg::COORD_W-1:0] goal_x;
  logic [gclt_pkg::COORD_W-1:0] goal_y;
  modport source(output valid, start_x, start_y, goal_x, goal_y, input ready);
  modport sink(input valid, start_x, start_y, goal_x, goal_y, output ready);
endinterface

interface gclt_out_if;
  logic                        valid;
  logic                        ready;
  logic [gclt_pkg::CELL_W-1:0] cell_x;
  logic [gclt_pkg::CELL_W-1:0] cell_y;
  logic                        last_cell;
  logic                        out_of_range;
  modport source(output valid, cell_x, cell_y, last_cell, out_of_range, input ready);
  modport sink(input valid, cell_x, cell_y, last_cell, out_of_range, output ready);
endinterface

// ----- rtl/gclt_div.sv -----
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
module gclt_div #(
  parameter int DW = 45,
  parameter int VW = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DW-1:0]            dividend,
  input  logic [VW-1:0]            divisor,
  input  logic [$clog2(DW+1)-1:0]  nbits,
  output logic                     done,
  output logic [DW-1:0]            quo,
  output logic [VW-1:0]            rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    quo_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dvs_r;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;
  logic [DW-1:0]    quo_nxt;
  logic [VW-1:0]    rem_nxt;

  assign trial   = {rem_r, quo_r[DW-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = trial >= {1'b0, dvs_r};
  assign quo_nxt = {quo_r[DW-2:0], ge};
  assign rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/gclt_front.sv -----
// Front end: takes a segment, finds cell indices and crossing times, queues a descriptor.
module gclt_front #(
  parameter int MAP_CELLS = gclt_pkg::MAP_CELLS_DEF,
  parameter int TFB       = gclt_pkg::TIME_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gclt_in_if.sink                    in_ch,
  input  logic [gclt_pkg::CFG_W-1:0] cell_size,
  input  logic                       q_full,
  output logic                       q_push,
  output gclt_pkg::desc_t            q_data
);

  localparam int CW  = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int DW  = gclt_pkg::NUM_W + TFB;
  localparam int DCW = $clog2(DW + 1);
  localparam int IW  = gclt_pkg::COORD_W;
  localparam int EW  = gclt_pkg::EDGE_W;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_DIVS = 6'b000010,
    F_DIVG = 6'b000100,
    F_DIVT = 6'b001000,
    F_DIVD = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [IW-1:0] sx_r, sy_r, gx_r, gy_r;
  logic [CW-1:0] scx_r, scy_r, gcx_r, gcy_r;
  logic [EW-1:0] rsx_r, rsy_r;
  logic [DW-1:0] t0x_r, t0y_r, dtx_r, dty_r;
  logic          oor_r;

  logic [EW-1:0]              edge_len;
  logic                       acc;
  logic                       div_go;
  logic [DW-1:0]              dvd_x, dvd_y, quo_x, quo_y;
  logic [EW-1:0]              dvs_x, dvs_y, rem_x, rem_y;
  logic [DCW-1:0]             dbits;
  logic                       done_x, done_y;
  logic                       start_oor, goal_oor;
  logic [IW-1:0]              mag_x, mag_y;
  logic [gclt_pkg::NUM_W-1:0] num_x, num_y;

  assign edge_len    = {cell_size, {gclt_pkg::IN_FRAC{1'b0}}};
  assign in_ch.ready = (state_r == F_IDLE);
  assign acc         = in_ch.valid & in_ch.ready;

  assign start_oor = (quo_x[IW-1:0] >= IW'(MAP_CELLS)) || (quo_y[IW-1:0] >= IW'(MAP_CELLS));
  assign goal_oor  = start_oor;
  assign mag_x = (gx_r > sx_r) ? gx_r - sx_r : sx_r - gx_r;
  assign mag_y = (gy_r > sy_r) ? gy_r - sy_r : sy_r - gy_r;
  assign num_x = (gx_r > sx_r) ? {1'b0, edge_len} - {1'b0, rsx_r}
                               : {1'b0, edge_len} + {1'b0, rsx_r};
  assign num_y = (gy_r > sy_r) ? {1'b0, edge_len} - {1'b0, rsy_r}
                               : {1'b0, edge_len} + {1'b0, rsy_r};

  always_comb begin
    state_nxt = state_r;
    div_go    = 1'b0;
    dvd_x     = {in_ch.start_x, {(DW-IW){1'b0}}};
    dvd_y     = {in_ch.start_y, {(DW-IW){1'b0}}};
    dvs_x     = edge_len;
    dvs_y     = edge_len;
    dbits     = DCW'(IW);
    case (state_r)
      F_IDLE: begin
        if (acc) begin
          if (cell_size == '0) begin
            state_nxt = F_PUSH;
          end else begin
            div_go    = 1'b1;
            state_nxt = F_DIVS;
          end
        end
      end
      F_DIVS: begin
        if (done_x) begin
          div_go    = 1'b1;
          dvd_x     = {gx_r, {(DW-IW){1'b0}}};
          dvd_y     = {gy_r, {(DW-IW){1'b0}}};
          state_nxt = F_DIVG;
        end
      end
      F_DIVG: begin
        if (done_x) begin
          if (oor_r || goal_oor) begin
            state_nxt = F_PUSH;
          end else begin
            div_go    = 1'b1;
            dvd_x     = {num_x, {TFB{1'b0}}};
            dvd_y     = {num_y, {TFB{1'b0}}};
            dvs_x     = EW'(mag_x);
            dvs_y     = EW'(mag_y);
            dbits     = DCW'(DW);
            state_nxt = F_DIVT;
          end
        end
      end
      F_DIVT: begin
        if (done_x) begin
          div_go    = 1'b1;
          dvd_x     = {1'b0, edge_len, {TFB{1'b0}}};
          dvd_y     = {1'b0, edge_len, {TFB{1'b0}}};
          dvs_x     = EW'(mag_x);
          dvs_y     = EW'(mag_y);
          dbits     = DCW'(DW);
          state_nxt = F_DIVD;
        end
      end
      F_DIVD: begin
        if (done_x) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      sx_r  <= in_ch.start_x;
      sy_r  <= in_ch.start_y;
      gx_r  <= in_ch.goal_x;
      gy_r  <= in_ch.goal_y;
      oor_r <= (cell_size == '0);
    end
    if (done_x) begin
      case (state_r)
        F_DIVS: begin
          scx_r <= quo_x[CW-1:0];
          scy_r <= quo_y[CW-1:0];
          rsx_r <= rem_x;
          rsy_r <= rem_y;
          oor_r <= start_oor;
        end
        F_DIVG: begin
          gcx_r <= quo_x[CW-1:0];
          gcy_r <= quo_y[CW-1:0];
          oor_r <= oor_r | goal_oor;
        end
        F_DIVT: begin
          t0x_r <= quo_x;
          t0y_r <= quo_y;
        end
        F_DIVD: begin
          dtx_r <= quo_x;
          dty_r <= quo_y;
        end
        default: begin
        end
      endcase
    end
  end

  gclt_div #(.DW(DW), .VW(EW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(dvd_x), .divisor(dvs_x),
    .nbits(dbits), .done(done_x), .quo(quo_x), .rem(rem_x)
  );

  gclt_div #(.DW(DW), .VW(EW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(dvd_y), .divisor(dvs_y),
    .nbits(dbits), .done(done_y), .quo(quo_y), .rem(rem_y)
  );

  assign q_push = (state_r == F_PUSH) && !q_full;

  always_comb begin
    q_data     = '0;
    q_data.oor = oor_r;
    q_data.scx = gclt_pkg::CELL_W'(scx_r);
    q_data.scy = gclt_pkg::CELL_W'(scy_r);
    q_data.gcx = gclt_pkg::CELL_W'(gcx_r);
    q_data.gcy = gclt_pkg::CELL_W'(gcy_r);
    q_data.dxn = gx_r < sx_r;
    q_data.dxz = gx_r == sx_r;
    q_data.dyn = gy_r < sy_r;
    q_data.dyz = gy_r == sy_r;
    q_data.tx  = gclt_pkg::TIME_W_MAX'(t0x_r);
    q_data.ty  = gclt_pkg::TIME_W_MAX'(t0y_r);
    q_data.dtx = gclt_pkg::TIME_W_MAX'(dtx_r);
    q_data.dty = gclt_pkg::TIME_W_MAX'(dty_r);
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n) done_x == done_y)
    else $error("axis dividers out of step");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |=> !in_ch.ready)
    else $error("segment taken while dividing");

endmodule

// ----- rtl/gclt_fifo.sv -----
// Short descriptor queue between the front and back ends.
module gclt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gclt_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output gclt_pkg::desc_t pop_data,
  output logic            empty
);

  localparam int DEPTH = gclt_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  gclt_pkg::desc_t mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  assign full     = (cnt_r == CNTW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ----- rtl/gclt_back.sv -----
// Back end: walks the cells of one descriptor, one result word per cycle while out_ch.ready does not stall it.
module gclt_back #(
  parameter int MAP_CELLS = gclt_pkg::MAP_CELLS_DEF,
  parameter int TFB       = gclt_pkg::TIME_FRAC_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  gclt_pkg::desc_t q_data,
  output logic            q_pop,
  gclt_out_if.source      out_ch
);

  localparam int CW = gclt_pkg::CELL_W;
  localparam int TW = gclt_pkg::NUM_W + TFB + gclt_pkg::COUNT_W;
  localparam int NW = gclt_pkg::COUNT_W;
  localparam logic [CW-1:0] CMAX = CW'(MAP_CELLS - 1);

  logic          busy_r, pre_r, oor_r;
  logic [CW-1:0] cx_r, cy_r, gx_r, gy_r;
  logic          dxn_r, dxz_r, dyn_r, dyz_r;
  logic [TW-1:0] tx_r, ty_r, dtx_r, dty_r;
  logic [NW-1:0] n_r;

  logic          ov_r, olast_r, ooor_r;
  logic [CW-1:0] ocx_r, ocy_r;

  logic          emit;
  logic          mv_x, mv_y, at_goal, guard, step_x, off_map;
  logic          last, flag;
  logic [CW-1:0] nx, ny;

  assign emit  = busy_r && (!ov_r || out_ch.ready);
  assign q_pop = !busy_r && !q_empty;

  assign mv_x    = pre_r && (cx_r != gx_r) && dxn_r;
  assign mv_y    = pre_r && (cy_r != gy_r) && dyn_r;
  assign at_goal = (cx_r == gx_r) && (cy_r == gy_r);
  assign guard   = n_r >= NW'(gclt_pkg::GUARD_CELLS);
  assign step_x  = dyz_r || (!dxz_r && (tx_r < ty_r));
  assign off_map = step_x ? (dxn_r ? (cx_r == '0) : (cx_r == CMAX))
                          : (dyn_r ? (cy_r == '0) : (cy_r == CMAX));

  always_comb begin
    nx   = cx_r;
    ny   = cy_r;
    last = 1'b0;
    flag = 1'b0;
    if (oor_r) begin
      last = 1'b1;
      flag = 1'b1;
    end else if (mv_x || mv_y) begin
      nx = mv_x ? cx_r - CW'(1) : cx_r;
      ny = mv_y ? cy_r - CW'(1) : cy_r;
    end else if (at_goal) begin
      last = 1'b1;
    end else if (guard || off_map) begin
      last = 1'b1;
      flag = 1'b1;
    end else if (step_x) begin
      nx = dxn_r ? cx_r - CW'(1) : cx_r + CW'(1);
    end else begin
      ny = dyn_r ? cy_r - CW'(1) : cy_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pre_r <= 1'b1;
      oor_r <= q_data.oor;
      cx_r  <= q_data.scx;
      cy_r  <= q_data.scy;
      gx_r  <= q_data.gcx;
      gy_r  <= q_data.gcy;
      dxn_r <= q_data.dxn;
      dxz_r <= q_data.dxz;
      dyn_r <= q_data.dyn;
      dyz_r <= q_data.dyz;
      tx_r  <= q_data.tx[TW-1:0];
      ty_r  <= q_data.ty[TW-1:0];
      dtx_r <= q_data.dtx[TW-1:0];
      dty_r <= q_data.dty[TW-1:0];
      n_r   <= NW'(1);
    end else if (emit && !last) begin
      pre_r <= 1'b0;
      cx_r  <= nx;
      cy_r  <= ny;
      n_r   <= n_r + NW'(1);
      if (!(mv_x || mv_y)) begin
        if (step_x) begin
          tx_r <= tx_r + dtx_r;
        end else begin
          ty_r <= ty_r + dty_r;
        end
      end
    end
    if (emit) begin
      ocx_r   <= oor_r ? '0 : cx_r;
      ocy_r   <= oor_r ? '0 : cy_r;
      olast_r <= last;
      ooor_r  <= flag;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.cell_x       = ocx_r;
  assign out_ch.cell_y       = ocy_r;
  assign out_ch.last_cell    = olast_r;
  assign out_ch.out_of_range = ooor_r;

  a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> n_r <= NW'(gclt_pkg::GUARD_CELLS))
    else $error("cell count past guard");
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> !busy_r)
    else $error("walker still busy after last word");
  a_cell_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (ocx_r <= CMAX) && (ocy_r <= CMAX))
    else $error("result cell outside map");

endmodule

// ----- rtl/grid_line_cell_traversal_core.sv -----
// Top level of the grid cell traversal block: config register, front, queue, back.
// Usage:
//   in_ch  : one word per segment (start_x/y, goal_x/y, 4 fraction bits),
//            valid/ready; a word is taken when both are high.
//   out_ch : one word per visited cell (cell_x, cell_y, last_cell,
//            out_of_range); last_cell marks the final word of a segment.
//   cfg_we/cfg_wdata: writes the cell size; only while no segment is in flight.
// Timing: the front end passes each segment through its two axis dividers (two index
//   divisions of 16 quotient bits, two time divisions of DW quotient bits, with
//   DW = TIME_FRACTION_BITS + 21); an off-map segment skips the time divisions and a
//   zero cell size skips all four. The back end gives one word per cycle, up to 64
//   per segment, while out_ch.ready does not stall it. A two-word descriptor queue
//   lets the front work on the next segment while the back end is still walking, so
//   sustained rate is set by the divider loop. First words pass walker and output regs.
// Reset: synchronous, active low; clears queue and handshakes, cell size
//   returns to 256.
// Stall: a low out_ch.ready holds the output word; the walker, then the
//   queue, then in_ch.ready back up in turn, and nothing is dropped.
module grid_line_cell_traversal_core #(
  parameter int MAP_CELLS          = gclt_pkg::MAP_CELLS_DEF,
  parameter int TIME_FRACTION_BITS = gclt_pkg::TIME_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gclt_in_if.sink                    in_ch,
  gclt_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [gclt_pkg::CFG_W-1:0] cfg_wdata
);

  logic [gclt_pkg::CFG_W-1:0] cell_size_r;
  logic                       q_full, q_empty, q_push, q_pop;
  gclt_pkg::desc_t            q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= gclt_pkg::CELL_SIZE_RST;
    end else if (cfg_we) begin
      cell_size_r <= cfg_wdata;
    end
  end

  gclt_front #(.MAP_CELLS(MAP_CELLS), .TFB(TIME_FRACTION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cell_size(cell_size_r),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  gclt_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  gclt_back #(.MAP_CELLS(MAP_CELLS), .TFB(TIME_FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
    .out_ch(out_ch)
  );

endmodule

// ----- tb/sv/gclt_cell_checker.sv -----
// Checker: tracks cell size, predicts visited cells per segment, compares result words.
module gclt_cell_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  gclt_in_if                         in_ch,
  gclt_out_if                        out_ch,
  input  logic                       cfg_we,
  input  logic [gclt_pkg::CFG_W-1:0] cfg_wdata,
  output int                         errors,
  output int                         pending
);

  localparam longint unsigned NEVER = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int TFRAC = gclt_pkg::TIME_FRAC_DEF;
  localparam int CW    = gclt_pkg::CELL_W;
  localparam int IW    = gclt_pkg::COORD_W;
  localparam int MAPC  = gclt_pkg::MAP_CELLS_DEF;

  typedef struct {
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic          last;
    logic          oor;
  } cell_word_t;

  cell_word_t                 cells_due[$];
  logic [gclt_pkg::CFG_W-1:0] edge_units;

  function automatic void crossing_times(input longint unsigned p, input longint unsigned q,
                                         input longint unsigned e, input longint unsigned s,
                                         output longint unsigned t0,
                                         output longint unsigned dt, output int dir);
    longint unsigned num, mag;
    if (q > p) begin
      mag = q - p;
      num = (s + 1) * e - p;
      dir = 1;
    end else if (q < p) begin
      mag = p - q;
      num = p + e - s * e;
      dir = -1;
    end else begin
      t0 = NEVER;
      dt = NEVER;
      dir = 0;
      return;
    end
    t0 = (num << TFRAC) / mag;
    dt = (e << TFRAC) / mag;
  endfunction

  function automatic void add_cell(input int x, input int y);
    cell_word_t w;
    w.cx = x[CW-1:0];
    w.cy = y[CW-1:0];
    w.last = 1'b0;
    w.oor = 1'b0;
    cells_due = {cells_due, w};
  endfunction

  function automatic void walk_segment(input logic [IW-1:0] sx, input logic [IW-1:0] sy,
                                       input logic [IW-1:0] gx, input logic [IW-1:0] gy);
    longint unsigned e, scx, scy, gcx, gcy, tx, ty, dtx, dty;
    int cx, cy, gxi, gyi, dx, dy, nx, ny, n;
    bit moved, flagged;
    moved = 0;
    flagged = 0;
    e = longint'(edge_units) << gclt_pkg::IN_FRAC;
    if (e != 0) begin
      scx = sx / e; scy = sy / e; gcx = gx / e; gcy = gy / e;
    end
    if (e == 0 || scx >= MAPC || scy >= MAPC || gcx >= MAPC || gcy >= MAPC) begin
      add_cell(0, 0);
      cells_due[$].last = 1'b1;
      cells_due[$].oor = 1'b1;
      return;
    end
    crossing_times(sx, gx, e, scx, tx, dtx, dx);
    crossing_times(sy, gy, e, scy, ty, dty, dy);
    cx = int'(scx); cy = int'(scy); gxi = int'(gcx); gyi = int'(gcy);
    add_cell(cx, cy);
    n = 1;
    if (cx != gxi && dx < 0) begin cx--; moved = 1; end
    if (cy != gyi && dy < 0) begin cy--; moved = 1; end
    if (moved) begin
      add_cell(cx, cy);
      n++;
    end
    while (cx != gxi || cy != gyi) begin
      nx = cx; ny = cy;
      if (n >= gclt_pkg::GUARD_CELLS) begin flagged = 1; break; end
      if (tx < ty) begin
        nx += dx;
        tx += dtx;
      end else begin
        ny += dy;
        ty += dty;
      end
      if (nx < 0 || ny < 0 || nx >= MAPC || ny >= MAPC) begin
        flagged = 1;
        break;
      end
      cx = nx; cy = ny;
      add_cell(cx, cy);
      n++;
    end
    cells_due[$].last = 1'b1;
    cells_due[$].oor = flagged;
  endfunction

  always @(posedge clk) begin
    cell_word_t w;
    if (!rst_n) begin
      edge_units = gclt_pkg::CELL_SIZE_RST;
      cells_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) edge_units = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        walk_segment(in_ch.start_x, in_ch.start_y, in_ch.goal_x, in_ch.goal_y);
      if (out_ch.valid && out_ch.ready) begin
        if (cells_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word cell=(%0d,%0d) last=%b oor=%b", $time,
                   out_ch.cell_x, out_ch.cell_y, out_ch.last_cell, out_ch.out_of_range);
        end else begin
          w = cells_due.pop_front();
          if (out_ch.cell_x !== w.cx || out_ch.cell_y !== w.cy ||
              out_ch.last_cell !== w.last || out_ch.out_of_range !== w.oor) begin
            errors++;
            $display("%0t: mismatch exp cell=(%0d,%0d) last=%b oor=%b",
                     $time, w.cx, w.cy, w.last, w.oor,
                     " got cell=(%0d,%0d) last=%b oor=%b",
                     out_ch.cell_x, out_ch.cell_y, out_ch.last_cell, out_ch.out_of_range);
          end
        end
      end
    end
    pending = cells_due.size();
  end
endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top: segment stimulus, cell size phases, stalls and the verdict.
module testbench;

  localparam int CFGW = gclt_pkg::CFG_W;
  localparam int IW   = gclt_pkg::COORD_W;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CFGW-1:0] cfg_wdata = '0;
  int              errors;
  int              pending;
  bit              calm = 0;
  bit              hold_req = 0;
  logic [CFGW-1:0] cur_size = gclt_pkg::CELL_SIZE_RST;

  gclt_in_if  in_ch();
  gclt_out_if out_ch();

  grid_line_cell_traversal_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  gclt_cell_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: per-word stall, plus one long hold-off on request
  initial begin
    int stall;
    bit held;
    held = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 18);
      if (hold_req && !held) begin
        stall = 800;
        held = 1;
      end
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_seg(input logic [IW-1:0] sx, input logic [IW-1:0] sy,
                          input logic [IW-1:0] gx, input logic [IW-1:0] gy,
                          input bit no_gap = 0);
    int gap;
    gap = (calm || no_gap) ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.goal_x <= gx;
    in_ch.goal_y <= gy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_size(input logic [CFGW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_size = v;
  endtask

  function automatic logic [IW-1:0] pick_coord();
    int unsigned span;
    span = cur_size * 512;
    if (span == 0 || span > 65536) span = 65536;
    if ($urandom_range(0, 9) == 0) return IW'($urandom_range(0, 65535));
    return IW'($urandom_range(0, span - 1));
  endfunction

  task automatic random_segs(input int count, input bit no_gap = 0);
    logic [IW-1:0] sx, sy, gx, gy;
    repeat (count) begin
      sx = pick_coord(); sy = pick_coord(); gx = pick_coord(); gy = pick_coord();
      case ($urandom_range(0, 7))
        0: gx = sx;
        1: gy = sy;
        2: begin gx = sx ^ 16'h3; gy = sy ^ 16'h5; end
        default: ;
      endcase
      send_seg(sx, sy, gx, gy, no_gap);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.goal_x = '0;
    in_ch.goal_y = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset cell size: corners, zero axes, same cell, negative steps, ties
    send_seg(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_seg(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    send_seg(16'h1000, 16'h1000, 16'h1000, 16'h1000);
    send_seg(16'h1234, 16'h1235, 16'h1FFF, 16'h1000);
    send_seg(16'h0800, 16'h5000, 16'h0800, 16'hF000);
    send_seg(16'h7000, 16'h2000, 16'h1000, 16'h2000);
    send_seg(16'h0800, 16'h0800, 16'h8800, 16'h8800);
    send_seg(16'hF7FF, 16'h0001, 16'h0801, 16'hFFFE);
    send_seg(16'hA5A5, 16'h5A5A, 16'h5A5A, 16'hA5A5);
    random_segs(40);

    // smallest cell: off-map endpoints and long walks
    set_size(16'd1);
    send_seg(16'h0000, 16'h0000, 16'h01FF, 16'h01FF);
    send_seg(16'h01FF, 16'h0000, 16'h0000, 16'h01FF);
    send_seg(16'h0200, 16'h0000, 16'h0000, 16'h0000);
    send_seg(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_seg(16'h01FF, 16'h01FF, 16'h0000, 16'h0000);
    random_segs(60);

    set_size(16'hFFFF);
    send_seg(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    random_segs(20);

    // back-pressure: long receiver hold while segments keep coming
    set_size(16'd128);
    hold_req = 1;
    random_segs(30, 1);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    random_segs(40);

    set_size(16'd37);
    calm = 1;
    random_segs(50);
    calm = 0;
    random_segs(30);

    set_size(16'd3);
    random_segs(50);

    set_size(16'd256);
    random_segs(40);

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- grid_line_cell_traversal_core.f -----
rtl/gclt_pkg.sv
rtl/gclt_if.sv
rtl/gclt_div.sv
rtl/gclt_front.sv
rtl/gclt_fifo.sv
rtl/gclt_back.sv
rtl/grid_line_cell_traversal_core.sv
tb/sv/gclt_cell_checker.sv
tb/sv/testbench.sv
